// ===== src/gsw_pkg.sv =====
package gsw_pkg;

    // Field widths
    localparam int unsigned GADDR_W    = 41;   // Sv39x4 guest physical address
    localparam int unsigned PA_W       = 56;   // host physical address
    localparam int unsigned PPN_W      = 44;
    localparam int unsigned PTE_W      = 64;
    localparam int unsigned IN_ADDR_W  = 64;
    localparam int unsigned PAGE_OFS_W = 12;

    typedef logic [1:0] level_t;

    localparam level_t LVL_4K = 2'd0;
    localparam level_t LVL_2M = 2'd1;
    localparam level_t LVL_1G = 2'd2;

    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_PTE_RESP  = 1'b1;

    localparam logic RESULT_READ = 1'b0;
    localparam logic RESULT_DONE = 1'b1;

    typedef enum logic [1:0] {
        FAULT_NONE       = 2'd0,
        FAULT_GUEST_PAGE = 2'd1,
        FAULT_ACCESS     = 2'd2
    } fault_t;

    // PTE flag bits
    localparam int unsigned PTE_V_BIT   = 0;
    localparam int unsigned PTE_R_BIT   = 1;
    localparam int unsigned PTE_X_BIT   = 3;
    localparam int unsigned PTE_PPN_LSB = 10;

    // Byte offset of the PTE within the table at a given level (index * 8).
    // Level 2 takes the 11-bit x4 index; an out-of-range level is read as level 2.
    function automatic logic [PA_W-1:0] pte_offset(input logic [GADDR_W-1:0] gpa,
                                                   input level_t lvl);
        logic [10:0] idx;
        unique case (lvl)
            LVL_4K:  idx = {2'b00, gpa[20:12]};
            LVL_2M:  idx = {2'b00, gpa[29:21]};
            default: idx = gpa[40:30];
        endcase
        return {{(PA_W-14){1'b0}}, idx, 3'b000};
    endfunction

    function automatic logic [4:0] level_page_log2(input level_t lvl);
        logic [4:0] sh;
        unique case (lvl)
            LVL_4K:  sh = 5'd12;
            LVL_2M:  sh = 5'd21;
            default: sh = 5'd30;
        endcase
        return sh;
    endfunction

    // Superpage PPN must be zero below the page size
    function automatic logic misaligned(input logic [PPN_W-1:0] ppn, input level_t lvl);
        logic bad;
        unique case (lvl)
            LVL_4K:  bad = 1'b0;
            LVL_2M:  bad = |ppn[8:0];
            default: bad = |ppn[17:0];
        endcase
        return bad;
    endfunction

    // Page offset of the guest address for a page mapped at this level
    function automatic logic [PA_W-1:0] page_offset(input logic [GADDR_W-1:0] gpa,
                                                    input level_t lvl);
        logic [PA_W-1:0] ofs;
        unique case (lvl)
            LVL_4K:  ofs = {{(PA_W-12){1'b0}}, gpa[11:0]};
            LVL_2M:  ofs = {{(PA_W-21){1'b0}}, gpa[20:0]};
            default: ofs = {{(PA_W-30){1'b0}}, gpa[29:0]};
        endcase
        return ofs;
    endfunction

endpackage

// ===== src/guest_stage_page_walker.sv =====
// G-stage (Sv39x4) page table walker.
// Input channel (in_valid / in_stall) carries either a translate request
// (kind = 0, guest_addr) or a PTE read response (kind = 1, pte_word,
// access_error). Each request produces at most one result on the output
// channel (out_valid / out_stall): either a PTE read address (result_kind = 0)
// for the memory side to fetch, or a finished translation or fault
// (result_kind = 1). A response arriving with no walk in progress is consumed
// silently; a translate request while busy drops the walk in progress.
// The result is registered and shows in the cycle after the request is taken.
// Throughput is one request per cycle while in_stall is low; all decode, index
// and address sums sit in one combinational pass ahead of the result register.
// in_stall is raised only while a result is held and the receiver stalls, so
// a result waiting to be taken never blocks the pipe beyond that one slot.
// root_ppn is written through cfg_write / cfg_data, by the user only while idle;
// the block does not enforce this. Reset (rst_n, async, active low) clears the
// walk state, root_ppn and the result valid; no clearing pass is needed.
module guest_stage_page_walker (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write,
    input  logic [gsw_pkg::PPN_W-1:0]            cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 kind,
    input  logic [gsw_pkg::IN_ADDR_W-1:0]        guest_addr,
    input  logic [gsw_pkg::PTE_W-1:0]            pte_word,
    input  logic                                 access_error,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 result_kind,
    output logic [gsw_pkg::PA_W-1:0]             read_addr,
    output logic [gsw_pkg::PA_W-1:0]             phys_addr,
    output logic [gsw_pkg::PA_W-1:0]             page_base,
    output logic [4:0]                           page_size_log2,
    output logic [gsw_pkg::PTE_W-1:0]            leaf_entry,
    output logic [1:0]                           fault_code
);

    // Walk state
    logic                              busy_reg,  busy_next;
    gsw_pkg::level_t                   level_reg, level_next;
    logic [gsw_pkg::GADDR_W-1:0]       saved_reg, saved_next;
    logic [gsw_pkg::PA_W-1:0]          tbase_reg, tbase_next;
    logic [gsw_pkg::PPN_W-1:0]         root_ppn_reg;

    // Result register
    logic                              out_valid_reg;
    logic                              res_kind_reg,  res_kind_next;
    logic [gsw_pkg::PA_W-1:0]          read_addr_reg, read_addr_next;
    logic [gsw_pkg::PA_W-1:0]          phys_reg,      phys_next;
    logic [gsw_pkg::PA_W-1:0]          base_reg,      base_next;
    logic [4:0]                        size_reg,      size_next;
    logic [gsw_pkg::PTE_W-1:0]         leaf_reg,      leaf_next;
    gsw_pkg::fault_t                   fault_reg,     fault_next;
    logic                              res_valid;

    logic                              accept;
    gsw_pkg::level_t                   cur_lvl;
    gsw_pkg::level_t                   down_lvl;
    logic [gsw_pkg::PPN_W-1:0]         pte_ppn;
    logic [gsw_pkg::PA_W-1:0]          pte_base;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // Level 3 never occurs; treat it as the root level
    assign cur_lvl  = (level_reg == 2'd3) ? gsw_pkg::LVL_1G : level_reg;
    assign down_lvl = cur_lvl - 2'd1;
    assign pte_ppn  = pte_word[gsw_pkg::PTE_PPN_LSB +: gsw_pkg::PPN_W];
    assign pte_base = {pte_ppn, {gsw_pkg::PAGE_OFS_W{1'b0}}};

    always_comb
    begin
        busy_next      = busy_reg;
        level_next     = level_reg;
        saved_next     = saved_reg;
        tbase_next     = tbase_reg;

        res_valid      = 1'b0;
        res_kind_next  = gsw_pkg::RESULT_DONE;
        read_addr_next = '0;
        phys_next      = '0;
        base_next      = '0;
        size_next      = '0;
        leaf_next      = '0;
        fault_next     = gsw_pkg::FAULT_NONE;

        if (kind == gsw_pkg::KIND_TRANSLATE)
        begin
            res_valid = 1'b1;
            if (|guest_addr[gsw_pkg::IN_ADDR_W-1:gsw_pkg::GADDR_W])
            begin
                // address beyond 41 bits: fault straight away
                fault_next = gsw_pkg::FAULT_GUEST_PAGE;
                busy_next  = 1'b0;
                level_next = gsw_pkg::LVL_4K;
            end
            else
            begin
                busy_next      = 1'b1;
                level_next     = gsw_pkg::LVL_1G;
                saved_next     = guest_addr[gsw_pkg::GADDR_W-1:0];
                tbase_next     = {root_ppn_reg, {gsw_pkg::PAGE_OFS_W{1'b0}}};
                res_kind_next  = gsw_pkg::RESULT_READ;
                read_addr_next = tbase_next
                               + gsw_pkg::pte_offset(guest_addr[gsw_pkg::GADDR_W-1:0],
                                                     gsw_pkg::LVL_1G);
            end
        end
        else if (busy_reg)
        begin
            res_valid  = 1'b1;
            busy_next  = 1'b0;
            level_next = gsw_pkg::LVL_4K;
            if (access_error)
                fault_next = gsw_pkg::FAULT_ACCESS;
            else if (!pte_word[gsw_pkg::PTE_V_BIT])
                fault_next = gsw_pkg::FAULT_GUEST_PAGE;
            else if (|pte_word[gsw_pkg::PTE_X_BIT:gsw_pkg::PTE_R_BIT])
            begin
                // leaf
                if (gsw_pkg::misaligned(pte_ppn, cur_lvl))
                    fault_next = gsw_pkg::FAULT_GUEST_PAGE;
                else
                begin
                    base_next = pte_base;
                    phys_next = pte_base + gsw_pkg::page_offset(saved_reg, cur_lvl);
                    size_next = gsw_pkg::level_page_log2(cur_lvl);
                    leaf_next = pte_word;
                end
            end
            else if (cur_lvl == gsw_pkg::LVL_4K)
                fault_next = gsw_pkg::FAULT_GUEST_PAGE;   // pointer at the last level
            else
            begin
                busy_next      = 1'b1;
                level_next     = down_lvl;
                tbase_next     = pte_base;
                res_kind_next  = gsw_pkg::RESULT_READ;
                read_addr_next = pte_base + gsw_pkg::pte_offset(saved_reg, down_lvl);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            level_reg    <= gsw_pkg::LVL_4K;
            saved_reg    <= '0;
            tbase_reg    <= '0;
            root_ppn_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                root_ppn_reg <= cfg_data;
            if (accept)
            begin
                busy_reg  <= busy_next;
                level_reg <= level_next;
                saved_reg <= saved_next;
                tbase_reg <= tbase_next;
            end
            if (accept && res_valid)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
        begin
            res_kind_reg  <= res_kind_next;
            read_addr_reg <= read_addr_next;
            phys_reg      <= phys_next;
            base_reg      <= base_next;
            size_reg      <= size_next;
            leaf_reg      <= leaf_next;
            fault_reg     <= fault_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_kind    = res_kind_reg;
    assign read_addr      = read_addr_reg;
    assign phys_addr      = phys_reg;
    assign page_base      = base_reg;
    assign page_size_log2 = size_reg;
    assign leaf_entry     = leaf_reg;
    assign fault_code     = fault_reg;

endmodule
